// ===== rtl/wf_pkg.sv =====
// Types and constants shared by the 3x3 window filter.
`default_nettype none

package wf_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int H_W        = 12;
    localparam int CFG_W_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int SUM_W      = 12;
    localparam int GRAD_W     = 11;
    localparam int LINE_W     = 2 * PIX_W;

    // floor(x / 9) for x below 2^12 as (x * 7282) >> 16
    localparam int            DIV9_SHIFT = 16;
    localparam logic [12:0]   DIV9_MUL   = 13'd7282;
    localparam int            PROD_W     = SUM_W + 13;

    localparam logic [CFG_W_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [H_W-1:0]     RESET_HEIGHT = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_KERNEL_SELECT = 2'd2
    } cfg_reg_e;

    typedef enum logic {
        KERNEL_BOX     = 1'b0,
        KERNEL_PREWITT = 1'b1
    } kernel_e;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } wf_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last_of_frame;
    } wf_out_t;

    // Per-item control carried alongside the window column
    typedef struct packed {
        logic have;
        logic mask_top;
        logic mask_bottom;
        logic mask_left;
        logic mask_right;
        logic last;
    } wf_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bottom;
    } wf_col_t;

    typedef struct packed {
        logic                     have;
        logic                     last;
        logic [SUM_W-1:0]         box;
        logic signed [GRAD_W-1:0] grad;
    } wf_sum_t;

endpackage

`default_nettype wire

// ===== rtl/window_3x3_filter.sv =====
// Top level of the streaming 3x3 window filter: framing, line store and output.
//
//  channel  direction  handshake              payload
//  pix      in         pix_valid / pix_stall  wf_in_t  {pixel, flush}
//  res      out        res_valid / res_stall  wf_out_t {value, last_of_frame}
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per clock while pix_stall is low; a result reaches res through the
// line store read, the window sum and the registered divide or clamp.
// Both line buffers share one 16-bit wide RAM, read and written once per item;
// a same-entry read straight after a write is served from a bypass register.
// Reset clears counters, window and handshake state; the RAM is not cleared.
// A two-entry output stage absorbs res_stall; pix_stall rises only when it fills.
`default_nettype none

module window_3x3_filter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           pix_valid,
    output logic                                pix_stall,
    input  wire wf_pkg::wf_in_t                 pix,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output wf_pkg::wf_out_t                     res,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import wf_pkg::*;

    // configuration
    logic [WID_W-1:0] eff_w_reg;
    logic [H_W-1:0]   eff_h_reg;
    kernel_e          kernel_reg;
    logic             cfg_write;
    logic             geom_write;
    logic [CFG_W_W-1:0] raw_w;

    // framing counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [H_W-1:0]   row_reg, row_next;
    logic [WID_W-1:0] flush_reg, flush_next;

    // request decode
    logic             advance;
    logic             pix_accept;
    logic             tail;
    logic             bad;
    logic [COL_W-1:0] col_c, lb_a, cc_a, w_m1;
    logic [H_W-1:0]   row_c, cr_a, h_m1;
    logic [WID_W-1:0] flush_c;
    logic             have_a;
    wf_ctl_t          ctl_a;
    logic [PIX_W-1:0] data_a;

    // line store stage
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_lb_reg;
    logic [PIX_W-1:0] s1_data_reg;
    logic             s1_fwd_reg;
    wf_ctl_t          s1_ctl_reg;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] entry;
    logic [LINE_W-1:0] wr_data;
    logic [LINE_W-1:0] wr_data_reg;
    logic             wr_en;
    wf_col_t          col_b;

    // sum stage and result
    logic             s2_valid;
    wf_sum_t          s2;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0] quot;
    logic [PIX_W-1:0] clamped;
    wf_out_t          result;
    logic             result_valid;

    // output stage
    logic             out_valid_reg, out_valid_next;
    wf_out_t          out_reg, out_next;
    logic             skid_valid_reg, skid_valid_next;
    wf_out_t          skid_reg, skid_next;
    logic             out_taken;

    // ---------------------------------------------------------------- config
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign geom_write = cfg_write && (cfg_index == CFG_FRAME_WIDTH ||
                                      cfg_index == CFG_FRAME_HEIGHT);
    assign raw_w      = cfg_data[CFG_W_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg  <= WID_W'(RESET_WIDTH);
            eff_h_reg  <= RESET_HEIGHT;
            kernel_reg <= KERNEL_BOX;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    if (raw_w == '0)
                    begin
                        eff_w_reg <= WID_W'(1);
                    end
                    else if (32'(raw_w) > MAX_WIDTH)
                    begin
                        eff_w_reg <= WID_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        eff_w_reg <= WID_W'(raw_w);
                    end
                end
                CFG_FRAME_HEIGHT:
                begin
                    eff_h_reg <= (cfg_data == '0) ? H_W'(1) : cfg_data;
                end
                CFG_KERNEL_SELECT:
                begin
                    kernel_reg <= kernel_e'(cfg_data[0]);
                end
                default:
                begin
                    // unknown index: ignore
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- decode
    assign advance    = !skid_valid_reg;
    assign pix_stall  = skid_valid_reg;
    assign pix_accept = pix_valid && !pix_stall;
    assign data_a     = pix.flush ? '0 : pix.pixel;
    assign w_m1       = COL_W'(eff_w_reg - 1'b1);
    assign h_m1       = eff_h_reg - 1'b1;

    always_comb
    begin
        bad = (row_reg > eff_h_reg) || ({1'b0, col_reg} >= eff_w_reg) ||
              (flush_reg > eff_w_reg);
        col_c   = bad ? '0 : col_reg;
        row_c   = bad ? '0 : row_reg;
        flush_c = bad ? '0 : flush_reg;
        tail    = (row_c == eff_h_reg);

        if (!tail)
        begin
            lb_a = col_c;
            if (col_c != '0)
            begin
                have_a = (row_c != '0);
                cr_a   = row_c - 1'b1;
                cc_a   = col_c - 1'b1;
            end
            else
            begin
                have_a = (row_c >= H_W'(2));
                cr_a   = row_c - H_W'(2);
                cc_a   = w_m1;
            end
        end
        else
        begin
            lb_a = (flush_c < eff_w_reg) ? COL_W'(flush_c) : '0;
            if (flush_c == '0)
            begin
                have_a = (eff_h_reg >= H_W'(2));
                cr_a   = h_m1 - 1'b1;
                cc_a   = w_m1;
            end
            else
            begin
                have_a = 1'b1;
                cr_a   = h_m1;
                cc_a   = COL_W'(flush_c - 1'b1);
            end
        end

        ctl_a.have        = have_a;
        ctl_a.mask_top    = (cr_a == '0);
        ctl_a.mask_bottom = (cr_a == h_m1);
        ctl_a.mask_left   = (cc_a == '0);
        ctl_a.mask_right  = (cc_a == w_m1);
        ctl_a.last        = (cr_a == h_m1) && (cc_a == w_m1);
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        flush_next = flush_reg;
        if (geom_write)
        begin
            col_next   = '0;
            row_next   = '0;
            flush_next = '0;
        end
        else if (pix_accept)
        begin
            col_next   = col_c;
            row_next   = row_c;
            flush_next = flush_c;
            if (!tail)
            begin
                if (col_c == w_m1)
                begin
                    col_next = '0;
                    row_next = row_c + 1'b1;
                    if (row_c + 1'b1 == eff_h_reg)
                    begin
                        flush_next = '0;
                    end
                end
                else
                begin
                    col_next = col_c + 1'b1;
                end
            end
            else if (flush_c == eff_w_reg)
            begin
                // frame done: restart
                col_next   = '0;
                row_next   = '0;
                flush_next = '0;
            end
            else
            begin
                flush_next = flush_c + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            flush_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            flush_reg <= flush_next;
        end
    end

    // ------------------------------------------------------------ line store
    // Entry holds {line above, line middle} for one column
    wf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_lb_reg),
        .wr_data (wr_data),
        .rd_en   (pix_accept),
        .rd_addr (lb_a),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pix_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_lb_reg   <= lb_a;
            s1_data_reg <= data_a;
            s1_ctl_reg  <= ctl_a;
            // same entry written this cycle: take it from the bypass next cycle
            s1_fwd_reg  <= s1_valid_reg && (s1_lb_reg == lb_a);
        end
        if (wr_en)
        begin
            wr_data_reg <= wr_data;
        end
    end

    assign entry      = s1_fwd_reg ? wr_data_reg : ram_rdata;
    assign col_b.top    = entry[LINE_W-1:PIX_W];
    assign col_b.mid    = entry[PIX_W-1:0];
    assign col_b.bottom = s1_data_reg;
    assign wr_en      = s1_valid_reg && advance;
    assign wr_data    = {col_b.mid, s1_data_reg};

    wf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .col_valid (s1_valid_reg),
        .col       (col_b),
        .ctl       (s1_ctl_reg),
        .sum_valid (s2_valid),
        .sum       (s2)
    );

    // ------------------------------------------------------------ result
    assign prod    = PROD_W'(s2.box) * PROD_W'(DIV9_MUL);
    assign quot    = prod[DIV9_SHIFT+PIX_W-1:DIV9_SHIFT];

    always_comb
    begin
        priority if (s2.grad < 0)
        begin
            clamped = '0;
        end
        else if (s2.grad > GRAD_W'(255))
        begin
            clamped = '1;
        end
        else
        begin
            clamped = s2.grad[PIX_W-1:0];
        end
    end

    assign result.value         = (kernel_reg == KERNEL_BOX) ? quot : clamped;
    assign result.last_of_frame = s2.last;
    assign result_valid         = advance && s2_valid && s2.have;

    // ------------------------------------------------------------ output
    assign out_taken = out_valid_reg && !res_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_taken)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result_valid)
        begin
            if (!out_valid_reg || out_taken)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                // output held: park in the skid entry
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_taken)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // ------------------------------------------------------------ checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && res_stall))
        else $error("skid entry filled without a held output");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < eff_w_reg)
        else $error("column counter beyond frame width");

    a_row_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= eff_h_reg) && (flush_reg <= eff_w_reg))
        else $error("row or trailing counter out of range");

    a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> $stable(s1_lb_reg) && $stable(s1_data_reg))
        else $error("line store stage changed while held");

endmodule

`default_nettype wire

// ===== rtl/wf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module wf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/wf_window.sv =====
// 3x3 window register with masked box sum and horizontal gradient stage.
`default_nettype none

module wf_window (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             col_valid,
    input  wire wf_pkg::wf_col_t  col,
    input  wire wf_pkg::wf_ctl_t  ctl,
    output logic                  sum_valid,
    output wf_pkg::wf_sum_t       sum
);

    import wf_pkg::*;

    logic [PIX_W-1:0] win_reg  [3][3];
    logic [PIX_W-1:0] win_next [3][3];
    logic [PIX_W-1:0] m        [3][3];
    logic             shift;
    logic             sum_valid_reg;
    wf_sum_t          sum_reg;
    wf_sum_t          sum_next;
    logic [9:0]       right_sum;
    logic [9:0]       left_sum;

    assign shift = advance && col_valid;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = col.top;
        win_next[1][2] = col.mid;
        win_next[2][2] = col.bottom;
    end

    // Zero every tap that falls outside the frame
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m[i][j] = win_next[i][j];
                if ((i == 0 && ctl.mask_top) || (i == 2 && ctl.mask_bottom) ||
                    (j == 0 && ctl.mask_left) || (j == 2 && ctl.mask_right))
                begin
                    m[i][j] = '0;
                end
            end
        end
    end

    always_comb
    begin
        right_sum = 10'(m[0][2]) + 10'(m[1][2]) + 10'(m[2][2]);
        left_sum  = 10'(m[0][0]) + 10'(m[1][0]) + 10'(m[2][0]);
        sum_next.have = ctl.have;
        sum_next.last = ctl.last;
        sum_next.box  = SUM_W'(right_sum) + SUM_W'(left_sum)
                      + SUM_W'(m[0][1]) + SUM_W'(m[1][1]) + SUM_W'(m[2][1]);
        sum_next.grad = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
            sum_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_valid_reg <= col_valid;
            if (col_valid)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

`default_nettype wire
